>>> design/fir131_pkg.sv
`timescale 1ns / 1ps
// Package for the 131-tap FIR filter: types, widths and the coefficient ROM.
package fir131_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = 32;
    localparam int ROM_IDX_W = 8;
    localparam int ROM_TAPS = 131;
    localparam int ROM_HALF = 66;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FINAL = 4'b1000
    } t_state;

    typedef logic signed [COEF_W-1:0] t_coef;

    localparam t_coef COEF_HALF [ROM_HALF] = '{
        16'sd9, 16'sd20, 16'sd32, 16'sd42, 16'sd49, 16'sd52, 16'sd48, 16'sd38, 16'sd21,
        -16'sd3, -16'sd34, -16'sd70, -16'sd109, -16'sd149, -16'sd186, -16'sd218,
        -16'sd242, -16'sd256, -16'sd257, -16'sd247, -16'sd223, -16'sd189, -16'sd145,
        -16'sd96, -16'sd44, 16'sd4, 16'sd47, 16'sd79, 16'sd97, 16'sd100, 16'sd87,
        16'sd58, 16'sd18, -16'sd32, -16'sd84, -16'sd132, -16'sd170, -16'sd190,
        -16'sd187, -16'sd155, -16'sd91, 16'sd5, 16'sd132, 16'sd285, 16'sd458,
        16'sd640, 16'sd822, 16'sd990, 16'sd1132, 16'sd1236, 16'sd1290, 16'sd1287,
        16'sd1220, 16'sd1087, 16'sd891, 16'sd637, 16'sd333, -16'sd5, -16'sd364,
        -16'sd726, -16'sd1072, -16'sd1385, -16'sd1648, -16'sd1846, -16'sd1970,
        16'sd30756
    };

    // Q1.15 coefficient h[k]; symmetric, zero beyond the ROM
    function automatic t_coef rom_q15(input logic [ROM_IDX_W-1:0] k);
        logic [ROM_IDX_W-1:0] mirror;
        t_coef                c;
        mirror = ROM_IDX_W'(ROM_TAPS - 1) - k;
        if (k >= ROM_IDX_W'(ROM_TAPS)) begin
            c = '0;
        end else if (k < ROM_IDX_W'(ROM_HALF)) begin
            c = COEF_HALF[k[6:0]];
        end else begin
            c = COEF_HALF[mirror[6:0]];
        end
        return c;
    endfunction

endpackage

>>> design/fir_filter_131_tap.sv
`timescale 1ns / 1ps
// Top level: direct-form FIR filter with one shared multiply-accumulate unit.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+------------------------
//  input   | i_in_valid  | o_in_ready  | i_sample_in  (s16)
//  output  | o_out_valid | i_out_ready | o_sample_out (s16)
//
// Each item runs one MAC step per tap through a single RAM read port and one
// 16x16 multiplier, then drains the MAC pipeline and rounds in ST_FINAL, where
// it waits for a free output register; the next item is taken in idle.
// o_in_ready is high only when idle.
// Reset clears the history valid bits at once; no clearing pass is needed.
// A stalled output holds the result; the next item is taken meanwhile.
module fir_filter_131_tap #(
    parameter int TAP_COUNT      = 131,
    parameter int COEF_FRAC_BITS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_sample_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_sample_out
);

    localparam int PTR_W   = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int ACC_W   = fir131_pkg::PROD_W + PTR_W + 1;
    localparam int C_SHIFT = 15 - COEF_FRAC_BITS;
    localparam int C_HALF  = (C_SHIFT == 0) ? 0 : (1 << (C_SHIFT - 1));
    localparam int RND     = 1 << (COEF_FRAC_BITS - 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(TAP_COUNT - 1);
    localparam logic signed [ACC_W:0] SAT_HI = (ACC_W+1)'(32767);
    localparam logic signed [ACC_W:0] SAT_LO = (ACC_W+1)'(-32768);

    fir131_pkg::t_state r_state, n_state;

    logic [PTR_W-1:0]         r_ptr;
    logic [PTR_W-1:0]         r_idx;
    logic [PTR_W-1:0]         r_k;
    logic [TAP_COUNT-1:0]     r_vld;
    logic                     r_vld_d1;
    logic                     r_p1;
    logic                     r_p2;
    fir131_pkg::t_coef        r_coef;
    logic signed [31:0]       r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic [15:0]              r_out;

    logic                     w_accept;
    logic                     w_issue;
    logic                     w_load;
    logic [15:0]              w_rdata;
    logic signed [15:0]       w_x;
    fir131_pkg::t_coef        w_c15;
    logic signed [16:0]       w_cb;
    logic signed [16:0]       w_cs;
    logic signed [ACC_W:0]    w_rnd;
    logic signed [ACC_W:0]    w_shr;
    logic [15:0]              w_sat;

    assign o_in_ready = (r_state == fir131_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_issue    = (r_state == fir131_pkg::ST_MAC);
    assign w_load     = (r_state == fir131_pkg::ST_FINAL) && (!r_out_valid || i_out_ready);

    fir131_ram #(
        .WIDTH (16),
        .DEPTH (TAP_COUNT)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_ptr),
        .i_wdata (i_sample_in),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // coefficient rescaled to COEF_FRAC_BITS, rounded half up
    always_comb begin
        w_c15 = fir131_pkg::rom_q15(fir131_pkg::ROM_IDX_W'(r_k));
        w_cb  = {w_c15[15], w_c15} + 17'(C_HALF);
        w_cs  = w_cb >>> C_SHIFT;
    end

    assign w_x = r_vld_d1 ? $signed(w_rdata) : 16'sd0;

    always_comb begin
        w_rnd = {r_acc[ACC_W-1], r_acc} + (ACC_W+1)'(RND);
        w_shr = w_rnd >>> COEF_FRAC_BITS;
        if (w_shr > SAT_HI) begin
            w_sat = 16'h7fff;
        end else if (w_shr < SAT_LO) begin
            w_sat = 16'h8000;
        end else begin
            w_sat = w_shr[15:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fir131_pkg::ST_IDLE:  if (w_accept) n_state = fir131_pkg::ST_MAC;
            fir131_pkg::ST_MAC:   if (r_k == LAST) n_state = fir131_pkg::ST_DRAIN;
            fir131_pkg::ST_DRAIN: if (!r_p1 && !r_p2) n_state = fir131_pkg::ST_FINAL;
            fir131_pkg::ST_FINAL: if (w_load) n_state = fir131_pkg::ST_IDLE;
            default:              n_state = fir131_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fir131_pkg::ST_IDLE;
            r_ptr       <= '0;
            r_vld       <= '0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p1    <= w_issue;
            r_p2    <= r_p1;
            if (w_accept) begin
                r_vld[r_ptr] <= 1'b1;
                r_ptr        <= (r_ptr == LAST) ? '0 : r_ptr + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx <= r_ptr;
            r_k   <= '0;
            r_acc <= '0;
        end else begin
            if (w_issue) begin
                r_idx <= (r_idx == '0) ? LAST : r_idx - 1'b1;
                r_k   <= r_k + 1'b1;
            end
            if (r_p2) begin
                r_acc <= r_acc + {{(ACC_W-32){r_prod[31]}}, r_prod};
            end
        end
        r_vld_d1 <= r_vld[r_idx];
        r_coef   <= w_cs[15:0];
        r_prod   <= w_x * r_coef;
        if (w_load) begin
            r_out <= w_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == fir131_pkg::ST_MAC) && (r_k == '0) && (r_acc == '0))
        else $error("MAC sequence did not start cleanly");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ptr <= LAST))
        else $error("write pointer out of range");

    a_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2 |-> $past(r_p1))
        else $error("MAC pipeline out of order");

    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fir131_pkg::ST_FINAL) |-> (!r_p1 && !r_p2))
        else $error("rounding started before accumulation finished");

endmodule

>>> design/fir131_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module fir131_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 131
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 131-tap FIR filter with random handshake stalls.
module tb;

    localparam int  TAPS        = 131;
    localparam int  FRAC_BITS   = 15;
    localparam int  DRAIN_WAIT  = 2 * (TAPS + 5) + 20;
    localparam int  CYCLE_LIMIT = 1000000;

    // first half of the symmetric Q1.15 impulse response
    localparam int H_HALF [66] = '{
        9, 20, 32, 42, 49, 52, 48, 38, 21, -3,
        -34, -70, -109, -149, -186, -218, -242, -256, -257, -247,
        -223, -189, -145, -96, -44, 4, 47, 79, 97, 100,
        87, 58, 18, -32, -84, -132, -170, -190, -187, -155,
        -91, 5, 132, 285, 458, 640, 822, 990, 1132, 1236,
        1290, 1287, 1220, 1087, 891, 637, 333, -5, -364, -726,
        -1072, -1385, -1648, -1846, -1970, 30756
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_sample_in;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_sample_out;

    logic signed [15:0] filter_hist [TAPS];
    int                 hist_wr_idx;
    int                 tap_coef [TAPS];
    logic signed [15:0] expected_samples [$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int send_gap_max = 7;
    int recv_stall_max = 7;

    fir_filter_131_tap #(
        .TAP_COUNT      (TAPS),
        .COEF_FRAC_BITS (FRAC_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int coef_at(input int k);
        int c15;
        int s;
        int half;
        if (k >= 131) begin
            return 0;
        end
        c15 = (k < 66) ? H_HALF[k] : H_HALF[130 - k];
        s = 15 - FRAC_BITS;
        half = (s == 0) ? 0 : (1 << (s - 1));
        return ((c15 + 32768 + half) >>> s) - (32768 >>> s);
    endfunction

    function automatic void clear_filter_state();
        for (int k = 0; k < TAPS; k++) begin
            filter_hist[k] = '0;
            tap_coef[k] = coef_at(k);
        end
        hist_wr_idx = 0;
    endfunction

    // shifts x into the history and returns the rounded, saturated y[n]
    function automatic logic signed [15:0] filter_output(input logic signed [15:0] x);
        longint acc;
        longint y;
        int     idx;
        acc = 0;
        filter_hist[hist_wr_idx] = x;
        for (int k = 0; k < TAPS; k++) begin
            idx = (hist_wr_idx + TAPS - k) % TAPS;
            acc += longint'(filter_hist[idx]) * longint'(tap_coef[k]);
        end
        hist_wr_idx = (hist_wr_idx + 1) % TAPS;
        y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (y > 32767) begin
            y = 32767;
        end else if (y < -32768) begin
            y = -32768;
        end
        return 16'(y);
    endfunction

    task automatic send_sample(input logic signed [15:0] x);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= x;
        do @(posedge i_clk); while (!o_in_ready);
        expected_samples.push_back(filter_output(x));
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
    endtask

    // output side: random backpressure, compare each item with the oldest prediction
    initial begin
        int                 stall;
        logic signed [15:0] want;
        forever begin
            stall = $urandom_range(0, recv_stall_max);
            @(negedge i_clk);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_rst_n));
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected sample_out, expected none, got %0d",
                         $time, $signed(o_sample_out));
                mismatch_count++;
            end else begin
                want = expected_samples.pop_front();
                if ($signed(o_sample_out) !== want) begin
                    $display("%0t: sample_out mismatch, expected %0d, got %0d",
                             $time, want, $signed(o_sample_out));
                    mismatch_count++;
                end
            end
        end
    end

    function automatic logic signed [15:0] pick_sample();
        logic signed [15:0] x;
        case ($urandom_range(0, 9)) inside
            [5:6]:   x = 16'($signed($urandom_range(0, 511)) - 256);
            7:       x = 16'sh7fff;
            8:       x = 16'sh8000;
            9:       x = '0;
            default: x = 16'($urandom);
        endcase
        return x;
    endfunction

    // field extremes, single impulses and alternating bit patterns
    task automatic test_directed();
        logic signed [15:0] seq [20];
        seq = '{16'sh7fff, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000, 16'sh0001,
                16'shffff, 16'sh0000, 16'sh5555, 16'shaaaa, 16'sh7fff, 16'sh7fff,
                16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh00ff,
                16'shff00, 16'sh0000};
        foreach (seq[i]) send_sample(seq[i]);
    endtask

    // fill the window with full-scale values matching each tap's sign (or its opposite when negative) to force clipping
    task automatic test_saturation(input bit negative);
        logic signed [15:0] x;
        int                 mag;
        for (int i = 0; i < TAPS; i++) begin
            mag = $urandom_range(30000, 32767);
            if ((tap_coef[i] < 0) ^ negative) begin
                x = 16'(-mag - ($urandom_range(0, 1)));
            end else begin
                x = 16'(mag);
            end
            send_sample(x);
        end
    endtask

    task automatic test_random_mix(input int count);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) begin
                wait_results_drained();
            end
            send_sample(pick_sample());
        end
    endtask

    task automatic test_back_to_back(input int count);
        send_gap_max   = 0;
        recv_stall_max = 0;
        for (int n = 0; n < count; n++) begin
            send_sample(pick_sample());
        end
        send_gap_max   = 7;
        recv_stall_max = 7;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample_in = '0;
        clear_filter_state();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_saturation(1'b0);
        test_saturation(1'b1);
        test_random_mix(380);
        test_back_to_back(60);
        test_random_mix(40);

        wait_results_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> files.f
design/fir131_pkg.sv
design/fir131_ram.sv
design/fir_filter_131_tap.sv
verif/tb.sv
